// ===== rtl/lia_pkg.sv =====
package lia_pkg;

	localparam int IDX_W  = 11;
	localparam int SIZE_W = 12;
	localparam int STS_W  = 2;

	localparam logic [SIZE_W-1:0] POOL_SIZE_RESET = 12'd2048;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_type_t;

	typedef enum logic [STS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FREE  = 2'd3
	} alloc_status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic exec;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

endpackage

// ===== rtl/lia_if.sv =====
interface lia_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [lia_pkg::IDX_W-1:0]   index;

	modport source (output valid, output req_type, output index, input ready);
	modport sink (input valid, input req_type, input index, output ready);
endinterface

interface lia_resp_if;
	logic                        valid;
	logic                        ready;
	logic [lia_pkg::IDX_W-1:0]   alloc_index;
	logic [lia_pkg::STS_W-1:0]   status;

	modport source (output valid, output alloc_index, output status, input ready);
	modport sink (input valid, input alloc_index, input status, output ready);
endinterface

interface lia_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [lia_pkg::SIZE_W-1:0]  pool_size;

	modport source (output valid, output pool_size, input ready);
	modport sink (input valid, input pool_size, output ready);
endinterface

// ===== rtl/lia_ctrl.sv =====
module lia_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  lia_pkg::dp_status_t sts,
	output lia_pkg::ctl_cmd_t   cmd
);
	import lia_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		cmd.accept = 1'b0;
		cmd.exec   = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!sts.out_busy) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == S_EXEC)
		else $error("Accepted beat did not move the controller to execute.");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && cmd.exec))
		else $error("Accept and execute issued in the same cycle.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && sts.out_busy) |-> !req_ready)
		else $error("New beat taken while the previous one is pending.");

endmodule

// ===== rtl/lia_dpath.sv =====
module lia_dpath #(
	parameter int MAX_INDICES = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lia_pkg::ctl_cmd_t           cmd,
	output lia_pkg::dp_status_t         sts,
	input  logic                        req_type,
	input  logic [lia_pkg::IDX_W-1:0]   index,
	input  logic                        cfg_valid,
	input  logic [lia_pkg::SIZE_W-1:0]  cfg_pool_size,
	input  logic                        resp_ready,
	output logic                        resp_valid,
	output logic [lia_pkg::IDX_W-1:0]   alloc_index,
	output logic [lia_pkg::STS_W-1:0]   status
);
	import lia_pkg::*;

	localparam int AW = $clog2(MAX_INDICES);
	localparam int CW = $clog2(MAX_INDICES + 1);
	localparam logic [16:0] MAX_EXT = 17'(MAX_INDICES);

	logic [IDX_W-1:0]  stack_mem [MAX_INDICES];
	logic              map_mem [MAX_INDICES];

	logic [SIZE_W-1:0] pool_size_q;
	logic [CW-1:0]     stack_count_q;
	logic [SIZE_W-1:0] fresh_next_q;
	logic              resp_valid_q;

	req_type_t         req_type_q;
	logic [IDX_W-1:0]  index_q;
	logic [IDX_W-1:0]  stack_rd_q;
	logic              map_rd_q;
	logic [IDX_W-1:0]  alloc_index_q;
	alloc_status_t     status_q;

	logic [SIZE_W-1:0] eff_size;
	logic              stack_nonempty;
	logic              stack_full;
	logic              fresh_ok;
	logic              pop;
	logic              take_fresh;
	logic              free_ok;
	logic              push;
	logic              idx_in_use;
	logic              map_we;
	logic              map_wdata;
	logic [AW-1:0]     map_waddr;
	logic [IDX_W-1:0]  result_index;
	alloc_status_t     result_status;

	assign eff_size = ({5'd0, pool_size_q} > MAX_EXT) ? SIZE_W'(MAX_INDICES) : pool_size_q;
	assign stack_nonempty = stack_count_q != '0;
	assign stack_full = stack_count_q == CW'(MAX_INDICES);
	assign fresh_ok = fresh_next_q < eff_size;
	assign idx_in_use = ({1'b0, index_q} < fresh_next_q) && map_rd_q;

	always_comb begin
		pop           = 1'b0;
		take_fresh    = 1'b0;
		free_ok       = 1'b0;
		result_index  = '0;
		result_status = ST_OK;
		map_we        = 1'b0;
		map_wdata     = 1'b0;
		map_waddr     = AW'(index_q);
		case (req_type_q)
			REQ_ALLOC: begin
				if (stack_nonempty) begin
					pop          = 1'b1;
					result_index = stack_rd_q;
					map_we       = 1'b1;
					map_wdata    = 1'b1;
					map_waddr    = AW'(stack_rd_q);
				end else if (fresh_ok) begin
					take_fresh   = 1'b1;
					result_index = fresh_next_q[IDX_W-1:0];
					map_we       = 1'b1;
					map_wdata    = 1'b1;
					map_waddr    = AW'(fresh_next_q);
				end else begin
					result_status = ST_EMPTY;
				end
			end
			REQ_FREE: begin
				if ({1'b0, index_q} >= eff_size) begin
					result_status = ST_RANGE;
				end else if (!idx_in_use) begin
					result_status = ST_FREE;
				end else begin
					free_ok = 1'b1;
					map_we  = 1'b1;
				end
			end
			default: begin
				result_status = ST_OK;
			end
		endcase
	end

	assign push = free_ok && !stack_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q   <= POOL_SIZE_RESET;
			stack_count_q <= '0;
			fresh_next_q  <= '0;
			resp_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				pool_size_q <= cfg_pool_size;
			end
			if (cmd.exec) begin
				resp_valid_q <= 1'b1;
				if (pop) begin
					stack_count_q <= stack_count_q - CW'(1);
				end else if (push) begin
					stack_count_q <= stack_count_q + CW'(1);
				end
				if (take_fresh) begin
					fresh_next_q <= fresh_next_q + SIZE_W'(1);
				end
			end else if (resp_ready) begin
				resp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_type_q <= req_type_t'(req_type);
			index_q    <= index;
			stack_rd_q <= stack_mem[AW'(stack_count_q - CW'(1))];
			map_rd_q   <= map_mem[AW'(index)];
		end
		if (cmd.exec) begin
			alloc_index_q <= result_index;
			status_q      <= result_status;
			if (push) begin
				stack_mem[AW'(stack_count_q)] <= index_q;
			end
			if (map_we) begin
				map_mem[map_waddr] <= map_wdata;
			end
		end
	end

	assign sts.out_busy = resp_valid_q && !resp_ready;
	assign resp_valid   = resp_valid_q;
	assign alloc_index  = alloc_index_q;
	assign status       = status_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		stack_count_q <= CW'(MAX_INDICES))
		else $error("Free stack count beyond its depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> fresh_next_q >= $past(fresh_next_q))
		else $error("Fresh index counter moved backward.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && pop) |=> stack_count_q == $past(stack_count_q) - CW'(1))
		else $error("Pop did not shrink the free stack.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(resp_valid_q) |-> $past(cmd.exec))
		else $error("Result shown without an executed request.");

endmodule

// ===== rtl/lifo_index_allocator.sv =====
// A request beat is accepted with registered reads of the free stack and in-use
// bitmap; the write-back and result register follow once any previous result
// has been taken, and no new request is accepted until that write-back is done.
// Reset clears the counters and the pool size returns to 2048; bitmap entries
// at or above the fresh index counter read as free, so no clearing pass is run.
module lifo_index_allocator #(
	parameter int MAX_INDICES = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	lia_req_if.sink           req,
	lia_resp_if.source        resp,
	lia_cfg_if.sink           cfg
);
	import lia_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t sts;

	assign cfg.ready = 1'b1;

	lia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lia_dpath #(
		.MAX_INDICES (MAX_INDICES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req.req_type),
		.index         (req.index),
		.cfg_valid     (cfg.valid),
		.cfg_pool_size (cfg.pool_size),
		.resp_ready    (resp.ready),
		.resp_valid    (resp.valid),
		.alloc_index   (resp.alloc_index),
		.status        (resp.status)
	);

endmodule
